@@ hdl/ptrlc_pkg.sv @@
package ptrlc_pkg;

  localparam int unsigned DivStages = 16;
  localparam int unsigned DivBitsPerStage = 2;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  typedef enum logic [2:0] {
    VERDICT_OK     = 3'd0,
    VERDICT_SIZE   = 3'd1,
    VERDICT_MARGIN = 3'd2,
    VERDICT_DD     = 3'd3,
    VERDICT_GROSS  = 3'd4,
    VERDICT_NET    = 3'd5
  } verdict_e;

  typedef enum logic [2:0] {
    REG_SIZE_MIN   = 3'd0,
    REG_SIZE_MAX   = 3'd1,
    REG_MARGIN_USE = 3'd2,
    REG_DD_CAP     = 3'd3,
    REG_GROSS_CAP  = 3'd4,
    REG_NET_CAP    = 3'd5,
    REG_LIVE_SCALE = 3'd6,
    REG_TEST_SCALE = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [46:0] size_min;
    logic [46:0] size_max;
    logic [31:0] margin_use;
    logic [31:0] dd_cap;
    logic [46:0] gross_cap;
    logic [46:0] net_cap;
    logic [31:0] live_scale;
    logic [31:0] test_scale;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic        live_trading;
    logic [47:0] account_equity;
    logic [47:0] equity_peak;
    logic [47:0] gross_now;
    logic [47:0] net_now;
    logic [47:0] order_size;
    logic [47:0] add_gross;
    logic [47:0] net_change;
    logic [47:0] margin_needed;
    logic [47:0] margin_free;
  } req_t;

  // Check results that ride alongside the drawdown divider.
  typedef struct packed {
    logic        dd_zero;
    logic        dd_sat;
    logic        size_bad;
    logic        margin_bad;
    logic        gross_bad;
    logic        net_bad;
    logic [47:0] dd_lim;
    logic [47:0] pgross;
    logic [48:0] pnet;
  } chk_t;

  typedef struct packed {
    logic [47:0] num;
    logic [46:0] peak;
  } div_t;

endpackage

@@ hdl/ptrlc_prep.sv @@
module ptrlc_prep import ptrlc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic vld_i,
  input  req_t req_i,
  input  cfg_t cfg_i,
  output logic vld_o,
  output chk_t chk_o,
  output div_t div_o
);

  // Stage 1: sign handling, sums and the size check.
  logic        s1_vld_q, s2_vld_q, s3_vld_q;
  logic        s1_ddz_q, s1_size_q, s1_mact_q;
  logic [47:0] s1_num_q;
  logic [46:0] s1_peak_q, s1_need_q, s1_free_q;
  logic [47:0] s1_pg_q;
  logic [48:0] s1_pn_q;
  logic [31:0] s1_mult_q;

  logic        ddz_d, size_d, mact_d;
  logic [48:0] diff, gsum, nsum, pn_d;
  logic [47:0] pg_d, asz;
  logic [31:0] mult_d;

  always_comb begin
    ddz_d = !(($signed(req_i.equity_peak) > 48'sd0) &&
              ($signed(req_i.equity_peak) > $signed(req_i.account_equity)));
    diff = {req_i.equity_peak[47], req_i.equity_peak}
         - {req_i.account_equity[47], req_i.account_equity};
    gsum = {req_i.gross_now[47], req_i.gross_now}
         + (($signed(req_i.add_gross) > 48'sd0) ? {1'b0, req_i.add_gross} : 49'd0);
    pg_d = (!gsum[48] && gsum != 49'd0) ? gsum[47:0] : 48'd0;
    nsum = {req_i.net_now[47], req_i.net_now} + {req_i.net_change[47], req_i.net_change};
    pn_d = nsum[48] ? (49'd0 - nsum) : nsum;
    asz = req_i.order_size[47] ? (48'd0 - req_i.order_size) : req_i.order_size;
    size_d = req_i.command && ((asz < {1'b0, cfg_i.size_min}) ||
                               (asz > {1'b0, cfg_i.size_max}));
    mact_d = req_i.command && ($signed(req_i.margin_needed) > 48'sd0) &&
             !req_i.margin_free[47];
    if (!req_i.command) begin
      mult_d = OneQ16;
    end else if (req_i.live_trading) begin
      mult_d = cfg_i.live_scale;
    end else begin
      mult_d = cfg_i.test_scale;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_ddz_q  <= ddz_d;
      s1_size_q <= size_d;
      s1_mact_q <= mact_d;
      s1_num_q  <= diff[47:0];
      s1_peak_q <= req_i.equity_peak[46:0];
      s1_need_q <= req_i.margin_needed[46:0];
      s1_free_q <= req_i.margin_free[46:0];
      s1_pg_q   <= pg_d;
      s1_pn_q   <= pn_d;
      s1_mult_q <= mult_d;
    end
  end

  // Stage 2: partial products of the limits and the usable margin.
  logic        s2_ddz_q, s2_size_q, s2_mact_q, s2_sat_q;
  logic [47:0] s2_num_q, s2_pg_q;
  logic [46:0] s2_peak_q, s2_need_q;
  logic [48:0] s2_pn_q;
  logic [63:0] s2_dp_q;
  logic [55:0] s2_gl_q, s2_nl_q, s2_ml_q;
  logic [54:0] s2_gh_q, s2_nh_q, s2_mh_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_ddz_q  <= s1_ddz_q;
      s2_size_q <= s1_size_q;
      s2_mact_q <= s1_mact_q;
      s2_sat_q  <= {15'd0, s1_num_q} >= {s1_peak_q, 16'd0};
      s2_num_q  <= s1_num_q;
      s2_peak_q <= s1_peak_q;
      s2_need_q <= s1_need_q;
      s2_pg_q   <= s1_pg_q;
      s2_pn_q   <= s1_pn_q;
      s2_dp_q   <= 64'(cfg_i.dd_cap) * 64'(s1_mult_q);
      s2_gl_q   <= 56'(cfg_i.gross_cap[23:0]) * 56'(s1_mult_q);
      s2_gh_q   <= 55'(cfg_i.gross_cap[46:24]) * 55'(s1_mult_q);
      s2_nl_q   <= 56'(cfg_i.net_cap[23:0]) * 56'(s1_mult_q);
      s2_nh_q   <= 55'(cfg_i.net_cap[46:24]) * 55'(s1_mult_q);
      s2_ml_q   <= 56'(s1_free_q[23:0]) * 56'(cfg_i.margin_use);
      s2_mh_q   <= 55'(s1_free_q[46:24]) * 55'(cfg_i.margin_use);
    end
  end

  // Stage 3: assemble the full products and compare.
  logic [78:0] gprod, nprod, mprod;
  chk_t        chk_d, s3_chk_q;
  div_t        s3_div_q;

  always_comb begin
    gprod = {s2_gh_q, 24'd0} + 79'(s2_gl_q);
    nprod = {s2_nh_q, 24'd0} + 79'(s2_nl_q);
    mprod = {s2_mh_q, 24'd0} + 79'(s2_ml_q);
    chk_d.dd_zero    = s2_ddz_q;
    chk_d.dd_sat     = s2_sat_q;
    chk_d.size_bad   = s2_size_q;
    chk_d.margin_bad = s2_mact_q && ({16'd0, s2_need_q, 16'd0} > mprod);
    chk_d.gross_bad  = {15'd0, s2_pg_q} > gprod[78:16];
    chk_d.net_bad    = {14'd0, s2_pn_q} > nprod[78:16];
    chk_d.dd_lim     = s2_dp_q[63:16];
    chk_d.pgross     = s2_pg_q;
    chk_d.pnet       = s2_pn_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_chk_q      <= chk_d;
      s3_div_q.num  <= s2_num_q;
      s3_div_q.peak <= s2_peak_q;
    end
  end

  assign vld_o = s3_vld_q;
  assign chk_o = s3_chk_q;
  assign div_o = s3_div_q;

endmodule

@@ hdl/ptrlc_div.sv @@
module ptrlc_div import ptrlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        vld_i,
  input  chk_t        chk_i,
  input  div_t        div_i,
  output logic        vld_o,
  output chk_t        chk_o,
  output logic [31:0] quot_o
);

  // Restoring division of num * 2^16 by peak, two quotient bits per stage.
  // The top 32 dividend bits start as the remainder; the rest shift in.
  logic        vld_q [DivStages];
  chk_t        chk_q [DivStages];
  logic [47:0] r_q   [DivStages];
  logic [31:0] f_q   [DivStages];
  logic [31:0] q_q   [DivStages];
  logic [46:0] d_q   [DivStages];

  logic [47:0] r_d [DivStages];
  logic [31:0] f_d [DivStages];
  logic [31:0] q_d [DivStages];

  always_comb begin
    logic [47:0] r;
    logic [31:0] f, q;
    logic [46:0] d;
    logic        ge;
    for (int s = 0; s < DivStages; s++) begin
      if (s == 0) begin
        r = {16'd0, div_i.num[47:16]};
        f = {div_i.num[15:0], 16'd0};
        q = 32'd0;
        d = div_i.peak;
      end else begin
        r = r_q[s-1];
        f = f_q[s-1];
        q = q_q[s-1];
        d = d_q[s-1];
      end
      for (int b = 0; b < DivBitsPerStage; b++) begin
        r  = {r[46:0], f[31]};
        f  = {f[30:0], 1'b0};
        ge = r >= {1'b0, d};
        if (ge) begin
          r = r - {1'b0, d};
        end
        q = {q[30:0], ge};
      end
      r_d[s] = r;
      f_d[s] = f;
      q_d[s] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DivStages; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < DivStages; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      chk_q[0] <= chk_i;
      d_q[0]   <= div_i.peak;
      for (int s = 1; s < DivStages; s++) begin
        chk_q[s] <= chk_q[s-1];
        d_q[s]   <= d_q[s-1];
      end
      for (int s = 0; s < DivStages; s++) begin
        r_q[s] <= r_d[s];
        f_q[s] <= f_d[s];
        q_q[s] <= q_d[s];
      end
    end
  end

  assign vld_o  = vld_q[DivStages-1];
  assign chk_o  = chk_q[DivStages-1];
  assign quot_o = q_q[DivStages-1];

endmodule

@@ hdl/pre_trade_risk_limit_check.sv @@
// Pipeline from an accepted request word to its verdict word:
// 3 check stages, 16 drawdown divider stages, 1 output register.
// Throughput: one request per cycle; the divider takes two quotient bits
// per stage and the whole pipeline holds while the output word waits.
// Reset clears the valid bits and loads every limit register with its default.
module pre_trade_risk_limit_check import ptrlc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // account_equity, equity_peak, gross_now, net_now, order_size, add_gross,
  // net_change, margin_needed, margin_free
  input  logic [431:0] s_axis_tdata,
  // command, live_trading
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // allowed, verdict_code, drawdown_value, gross_projected, net_projected, zero pad
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [46:0]  cfg_data_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_min   <= '0;
      cfg_q.size_max   <= '1;
      cfg_q.margin_use <= OneQ16;
      cfg_q.dd_cap     <= OneQ16;
      cfg_q.gross_cap  <= '1;
      cfg_q.net_cap    <= '1;
      cfg_q.live_scale <= OneQ16;
      cfg_q.test_scale <= OneQ16;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SIZE_MIN:   cfg_q.size_min   <= cfg_data_i;
        REG_SIZE_MAX:   cfg_q.size_max   <= cfg_data_i;
        REG_MARGIN_USE: cfg_q.margin_use <= cfg_data_i[31:0];
        REG_DD_CAP:     cfg_q.dd_cap     <= cfg_data_i[31:0];
        REG_GROSS_CAP:  cfg_q.gross_cap  <= cfg_data_i;
        REG_NET_CAP:    cfg_q.net_cap    <= cfg_data_i;
        REG_LIVE_SCALE: cfg_q.live_scale <= cfg_data_i[31:0];
        REG_TEST_SCALE: cfg_q.test_scale <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic adv;
  req_t req;
  logic prep_vld, div_vld;
  chk_t prep_chk, div_chk;
  div_t prep_div;
  logic [31:0] quot;

  // The whole pipeline moves unless the output word is held.
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    req.command        = s_axis_tuser[0];
    req.live_trading   = s_axis_tuser[1];
    req.account_equity = s_axis_tdata[47:0];
    req.equity_peak    = s_axis_tdata[95:48];
    req.gross_now      = s_axis_tdata[143:96];
    req.net_now        = s_axis_tdata[191:144];
    req.order_size     = s_axis_tdata[239:192];
    req.add_gross      = s_axis_tdata[287:240];
    req.net_change     = s_axis_tdata[335:288];
    req.margin_needed  = s_axis_tdata[383:336];
    req.margin_free    = s_axis_tdata[431:384];
  end

  ptrlc_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_axis_tvalid),
    .req_i  (req),
    .cfg_i  (cfg_q),
    .vld_o  (prep_vld),
    .chk_o  (prep_chk),
    .div_o  (prep_div)
  );

  ptrlc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (prep_vld),
    .chk_i  (prep_chk),
    .div_i  (prep_div),
    .vld_o  (div_vld),
    .chk_o  (div_chk),
    .quot_o (quot)
  );

  logic [31:0] dd;
  verdict_e    verdict;
  logic        out_vld_q;
  logic [135:0] out_data_q;

  always_comb begin
    if (div_chk.dd_zero) begin
      dd = 32'd0;
    end else if (div_chk.dd_sat) begin
      dd = '1;
    end else begin
      dd = quot;
    end
    if (div_chk.size_bad) begin
      verdict = VERDICT_SIZE;
    end else if (div_chk.margin_bad) begin
      verdict = VERDICT_MARGIN;
    end else if ({16'd0, dd} > div_chk.dd_lim) begin
      verdict = VERDICT_DD;
    end else if (div_chk.gross_bad) begin
      verdict = VERDICT_GROSS;
    end else if (div_chk.net_bad) begin
      verdict = VERDICT_NET;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {3'd0, div_chk.pnet, div_chk.pgross, dd, verdict,
                     verdict == VERDICT_OK};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ sim/tb.sv @@
module tb;
  import ptrlc_pkg::*;

  typedef struct {
    logic        command;
    logic        live_trading;
    logic [47:0] account_equity;
    logic [47:0] equity_peak;
    logic [47:0] gross_now;
    logic [47:0] net_now;
    logic [47:0] order_size;
    logic [47:0] add_gross;
    logic [47:0] net_change;
    logic [47:0] margin_needed;
    logic [47:0] margin_free;
  } order_t;

  typedef struct {
    logic        allowed;
    verdict_e    verdict;
    logic [31:0] drawdown;
    logic [47:0] gross_proj;
    logic [48:0] net_proj;
  } verdict_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [431:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [46:0]  cfg_data_i = '0;

  pre_trade_risk_limit_check u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Limit registers as the checker believes them to be.
  logic [46:0] lim_size_min, lim_size_max, lim_gross, lim_net;
  logic [31:0] lim_margin, lim_dd, lim_live, lim_test;

  order_t   pending_orders[$];
  verdict_t expected_verdicts[$];
  int       errors = 0;
  int       send_idle_pct = 10;
  int       recv_idle_pct = 75;
  int       recv_hold = 0;
  bit       send_hold = 1'b0;

  function automatic logic [63:0] scaled_limit(logic [46:0] cap, logic [31:0] mult);
    logic [79:0] prod;
    prod = {33'd0, cap} * {48'd0, mult};
    return prod[79:16];
  endfunction

  function automatic verdict_t judge_order(order_t o);
    verdict_t    v;
    logic signed [49:0] eq, pk, gsum, nsum, gadd;
    logic [63:0] mult, q;
    logic [47:0] asz;
    logic [111:0] mprod;
    logic signed [48:0] sz;
    eq = $signed(o.account_equity);
    pk = $signed(o.equity_peak);
    v.drawdown = '0;
    if (pk > 0 && pk > eq) begin
      q = ({14'd0, 50'(pk - eq)} << 16) / 64'(pk);
      v.drawdown = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
    end
    gadd = $signed(o.add_gross);
    gsum = $signed(o.gross_now) + (gadd > 0 ? gadd : 50'sd0);
    v.gross_proj = gsum > 0 ? gsum[47:0] : '0;
    nsum = $signed(o.net_now) + $signed(o.net_change);
    v.net_proj = nsum < 0 ? 49'(-nsum) : nsum[48:0];
    mult = o.command ? (o.live_trading ? lim_live : lim_test) : 64'(OneQ16);
    v.verdict = VERDICT_OK;
    if (o.command) begin
      sz = $signed(o.order_size);
      asz = sz < 0 ? 48'(-sz) : sz[47:0];
      if (asz < lim_size_min || asz > lim_size_max) v.verdict = VERDICT_SIZE;
      if (v.verdict == VERDICT_OK && $signed(o.margin_needed) > 0
          && !o.margin_free[47]) begin
        mprod = {64'd0, o.margin_free} * {80'd0, lim_margin};
        if ({48'd0, o.margin_needed, 16'd0} > mprod) v.verdict = VERDICT_MARGIN;
      end
    end
    if (v.verdict == VERDICT_OK && 64'(v.drawdown) > scaled_limit(47'(lim_dd), mult[31:0]))
      v.verdict = VERDICT_DD;
    if (v.verdict == VERDICT_OK && 64'(v.gross_proj) > scaled_limit(lim_gross, mult[31:0]))
      v.verdict = VERDICT_GROSS;
    if (v.verdict == VERDICT_OK && 64'(v.net_proj) > scaled_limit(lim_net, mult[31:0]))
      v.verdict = VERDICT_NET;
    v.allowed = v.verdict == VERDICT_OK;
    return v;
  endfunction

  task automatic add_order(order_t o);
    pending_orders.insert(pending_orders.size(), o);
  endtask

  // Driver: a word leaves the queue when the block accepts it.
  always @(posedge clk_i) begin
    order_t o;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 judge_order(pending_orders.pop_front()));
      end
      if ((!s_axis_tvalid || s_axis_tready) && !send_hold) begin
        if (pending_orders.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          o = pending_orders[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= {o.live_trading, o.command};
          s_axis_tdata <= {o.margin_free, o.margin_needed, o.net_change, o.add_gross,
                           o.order_size, o.net_now, o.gross_now, o.equity_peak,
                           o.account_equity};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The driver keeps a word offered until it is taken, so pending_orders[0] is on the bus.
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t unexpected verdict word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          e = expected_verdicts.pop_front();
          if (m_axis_tdata[0] !== e.allowed || m_axis_tdata[3:1] !== e.verdict
              || m_axis_tdata[35:4] !== e.drawdown || m_axis_tdata[83:36] !== e.gross_proj
              || m_axis_tdata[132:84] !== e.net_proj) begin
            $display("%0t mismatch: expected a=%b v=%0d dd=%h g=%h n=%h, got a=%b v=%0d dd=%h g=%h n=%h",
                     $time, e.allowed, e.verdict, e.drawdown, e.gross_proj, e.net_proj,
                     m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[35:4],
                     m_axis_tdata[83:36], m_axis_tdata[132:84]);
            errors++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [47:0] r;
    case ($urandom_range(5))
      0: r = 48'h7FFF_FFFF_FFFF;
      1: r = 48'h8000_0000_0000;
      2: r = 48'(signed'($urandom_range(200000)) - 100000);
      3: r = 48'({$urandom, $urandom} & 64'h0000_0000_FFFF_FFFF);
      default: r = 48'({$urandom, $urandom});
    endcase
    return r;
  endfunction

  function automatic order_t rand_order();
    order_t o;
    o.command = 1'($urandom_range(1));
    o.live_trading = 1'($urandom_range(1));
    o.account_equity = rand48();
    o.equity_peak = $urandom_range(3) == 0 ? rand48() : {1'b0, 15'd0, $urandom};
    if ($urandom_range(1)) o.account_equity = o.equity_peak - 48'($urandom_range(1 << 30));
    o.gross_now = rand48();
    o.net_now = rand48();
    o.order_size = rand48();
    o.add_gross = rand48();
    o.net_change = rand48();
    o.margin_needed = rand48();
    o.margin_free = rand48();
    return o;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [46:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIZE_MIN:   lim_size_min = val;
      REG_SIZE_MAX:   lim_size_max = val;
      REG_MARGIN_USE: lim_margin = val[31:0];
      REG_DD_CAP:     lim_dd = val[31:0];
      REG_GROSS_CAP:  lim_gross = val;
      REG_NET_CAP:    lim_net = val;
      REG_LIVE_SCALE: lim_live = val[31:0];
      default:        lim_test = val[31:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_orders.size() == 0 && !s_axis_tvalid);
    wait (expected_verdicts.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic random_config();
    write_reg(REG_SIZE_MIN, 47'($urandom_range(1 << 20)));
    write_reg(REG_SIZE_MAX, $urandom_range(3) == 0 ? 47'h7FFF_FFFF_FFFF :
                            {15'd0, $urandom});
    write_reg(REG_MARGIN_USE, 47'($urandom_range(131072)));
    write_reg(REG_DD_CAP, 47'($urandom_range(65536)));
    write_reg(REG_GROSS_CAP, {15'd0, $urandom});
    write_reg(REG_NET_CAP, {15'd0, $urandom});
    write_reg(REG_LIVE_SCALE, 47'($urandom_range(196608)));
    write_reg(REG_TEST_SCALE, 47'($urandom));
  endtask

  initial begin
    order_t o;
    lim_size_min = '0; lim_size_max = '1; lim_gross = '1; lim_net = '1;
    lim_margin = OneQ16; lim_dd = OneQ16; lim_live = OneQ16; lim_test = OneQ16;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at reset limits; OK, size, margin and drawdown verdicts.
    o = '{1'b0, 1'b0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0};
    add_order(o);
    o.account_equity = 48'h8000_0000_0000; o.equity_peak = 48'h7FFF_FFFF_FFFF;
    o.gross_now = 48'h7FFF_FFFF_FFFF; o.add_gross = 48'h7FFF_FFFF_FFFF;
    o.net_now = 48'h8000_0000_0000; o.net_change = 48'h8000_0000_0000;
    add_order(o);
    o.command = 1'b1; o.order_size = 48'h8000_0000_0000;
    add_order(o);
    o = '{1'b1, 1'b1, 48'd100, 48'd200, 48'd10, -48'sd5, 48'h1_0000, -48'sd3,
          48'd2, 48'h2_0000, 48'h1_0000};
    add_order(o);
    o.margin_free = 48'h8000_0000_0000; add_order(o);
    o.margin_needed = -48'sd1; o.equity_peak = -48'sd1; add_order(o);
    o.equity_peak = 48'd1; o.account_equity = 48'h8000_0000_0000; add_order(o);
    drain();

    write_reg(REG_SIZE_MIN, 47'h1_0000);
    write_reg(REG_SIZE_MAX, 47'h5_0000);
    write_reg(REG_MARGIN_USE, 47'h8000);
    write_reg(REG_DD_CAP, 47'h4000);
    write_reg(REG_GROSS_CAP, 47'h100_0000);
    write_reg(REG_NET_CAP, 47'h10_0000);
    write_reg(REG_LIVE_SCALE, 47'h2_0000);
    write_reg(REG_TEST_SCALE, 47'hFFFF_FFFF);
    o = '{1'b1, 1'b0, 48'h8_0000, 48'h10_0000, 48'h80_0000, 48'h1_0000, 48'h2_0000,
          48'h10_0000, 48'h1000, 48'h1_0000, 48'h4_0000};
    add_order(o);
    o.order_size = 48'hFFFF; add_order(o);
    o.order_size = -48'sh6_0000; add_order(o);
    o.order_size = 48'h5_0000; o.margin_needed = 48'h2_0001; add_order(o);
    o.margin_needed = 48'h2_0000; o.live_trading = 1'b1; add_order(o);
    o.account_equity = 48'h10_0000; o.gross_now = 48'h200_0000; add_order(o);
    o.gross_now = 48'd0; o.net_now = 48'h100_0000; add_order(o);
    o.command = 1'b0; add_order(o);
    drain();
    write_reg(REG_SIZE_MIN, 47'h7FFF_FFFF_FFFF);
    write_reg(REG_SIZE_MAX, 47'd0);
    write_reg(REG_MARGIN_USE, 47'hFFFF_FFFF);
    write_reg(REG_LIVE_SCALE, 47'd0);
    write_reg(REG_TEST_SCALE, 47'd0);
    for (int i = 0; i < 6; i++) add_order(rand_order());
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      if (phase == 3) begin
        send_idle_pct = 75; recv_idle_pct = 10;
      end
      if (phase == 6) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (phase == 2) recv_hold = 300;
      for (int i = 0; i < 100; i++) add_order(rand_order());
      if (phase == 4) begin
        wait (pending_orders.size() < 50);
        send_hold = 1'b1;
        wait (expected_verdicts.size() == 0);
        @(posedge clk_i);
        send_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

endmodule
